@@ design/coe_pkg.sv @@
// shared constants for the clock offset estimator
package coe_pkg;

	localparam int DATA_W       = 64;
	localparam int THR_W        = 32;
	localparam int SAMPLES      = 50;
	localparam int MAX_OUT      = 20;
	localparam int NEIGH        = 5;
	localparam int FAR_NEED     = 4;
	localparam int DEPTH        = 64;
	localparam int IDX_W        = 6;
	localparam int NB_W         = 3;
	localparam int LIST_W       = $clog2(MAX_OUT + 1);
	localparam int DIGIT_W      = 16;
	localparam int DIGITS       = DATA_W / DIGIT_W;
	localparam int DCNT_W       = $clog2(DIGITS);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	localparam logic [THR_W-1:0]     THR_RESET        = 32'd3277;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_TOUCH = 2'd1;

endpackage

@@ design/coe_serial_sub.sv @@
// digit-serial subtractor: x - y, and t minus that difference, one digit per cycle while step is high
module coe_serial_sub (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      step,
	input  logic [coe_pkg::DATA_W-1:0] x,
	input  logic [coe_pkg::DATA_W-1:0] y,
	input  logic [coe_pkg::DATA_W-1:0] t,
	output logic [coe_pkg::DATA_W-1:0] diff,
	output logic                      borrow,
	output logic                      nonzero,
	output logic                      t_borrow
);
	import coe_pkg::*;

	logic [DATA_W-1:0]  x_q, y_q, t_q, diff_q;
	logic               bor_q, tbor_q, nz_q;
	logic [DIGIT_W:0]   dsub, tsub;

	assign dsub = {1'b0, x_q[DIGIT_W-1:0]} - {1'b0, y_q[DIGIT_W-1:0]}
		- {{DIGIT_W{1'b0}}, bor_q};
	assign tsub = {1'b0, t_q[DIGIT_W-1:0]} - {1'b0, dsub[DIGIT_W-1:0]}
		- {{DIGIT_W{1'b0}}, tbor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bor_q  <= 1'b0;
			tbor_q <= 1'b0;
			nz_q   <= 1'b0;
		end else if (load) begin
			bor_q  <= 1'b0;
			tbor_q <= 1'b0;
			nz_q   <= 1'b0;
		end else if (step) begin
			bor_q  <= dsub[DIGIT_W];
			tbor_q <= tsub[DIGIT_W];
			nz_q   <= nz_q | (|dsub[DIGIT_W-1:0]);
		end
	end

	// operands shift out lsb digit first, difference fills from the top
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x;
			y_q <= y;
			t_q <= t;
		end else if (step) begin
			x_q    <= {{DIGIT_W{1'b0}}, x_q[DATA_W-1:DIGIT_W]};
			y_q    <= {{DIGIT_W{1'b0}}, y_q[DATA_W-1:DIGIT_W]};
			t_q    <= {{DIGIT_W{1'b0}}, t_q[DATA_W-1:DIGIT_W]};
			diff_q <= {dsub[DIGIT_W-1:0], diff_q[DATA_W-1:DIGIT_W]};
		end
	end

	assign diff     = diff_q;
	assign borrow   = bor_q;
	assign nonzero  = nz_q;
	assign t_borrow = tbor_q;

endmodule

@@ design/clock_offset_estimator.sv @@
// clock offset estimator top level: sample store, round sequencer, config registers
//
// A sync packet word is taken with start while busy is low. Every word gives
// exactly one result word, shown for one cycle with done high; the receiver
// cannot hold results off and none are dropped.
// A packet with a bad checksum answers in the cycle after start. A good packet
// that does not close the round answers once the 64-bit difference has run
// through the 16-bit digit-serial subtractors in 4 digits and is stored in S_WR.
// The packet that fills the last of 50 samples closes the round: 250 neighbour
// compares (states S_CRD, S_CLD, S_CRUN, S_CEV), then a minimum sweep that runs
// S_MRD, S_MLD, S_MRUN and S_MEV per kept sample and only S_MRD per blacklisted
// one; a discarded round answers from S_WR. The work runs on the digit subtractors
// and the two-read sample memory, and one packet is handled at a time.
// The config channel (cfg_valid/cfg_ready, always ready) writes index 0, the
// far threshold, and index 1, single-touch mode; write it only while idle.
// Reset clears the sample count and restores the register defaults; no
// clearing pass is needed, the sample memory is always written before read.
module clock_offset_estimator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              crc_ok,
	input  logic [coe_pkg::DATA_W-1:0]        center_time,
	input  logic [coe_pkg::DATA_W-1:0]        local_time,
	input  logic                              log_flag,
	input  logic                              is_sensing,
	input  logic                              discard_round,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [coe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [coe_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic                              response,
	output logic                              offset_valid,
	output logic                              offset_negative,
	output logic [coe_pkg::DATA_W-1:0]        offset_magnitude,
	output logic                              start_sensing,
	output logic                              round_done
);
	import coe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SUB, S_WR, S_CRD, S_CLD, S_CRUN, S_CEV, S_MRD, S_MLD, S_MRUN, S_MEV
	} state_t;

	state_t              state_q;
	logic [THR_W-1:0]    thr_q;
	logic                single_q;
	logic [IDX_W-1:0]    count_q, i_q;
	logic [NB_W-1:0]     j_q, far_q;
	logic [LIST_W-1:0]   listed_q;
	logic [DEPTH-1:0]    black_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                log_q, sens_q, disc_q;
	logic [DATA_W-1:0]   best_q, m_q;
	logic                bn_q, g_q, have_q;

	logic                done_q, resp_q, oval_q, oneg_q, ssens_q, rdone_q;
	logic [DATA_W-1:0]   omag_q;

	logic [DATA_W:0]     mem [DEPTH];
	logic [DATA_W:0]     rd0_q, rd1_q;
	logic [IDX_W-1:0]    rd0_addr, rd1_addr;
	logic                wr_en;
	logic [DATA_W:0]     wr_data;

	logic                load_a, load_b, step;
	logic [DATA_W-1:0]   ax, ay, bx, by, tt;
	logic [DATA_W-1:0]   a_diff, b_diff;
	logic                a_bor, a_nz, a_tb, b_bor, b_nz, b_tb;

	logic [IDX_W:0]      nb_sum;
	logic [IDX_W-1:0]    nb;
	logic                s_neg, far_hit, take, sens_req;
	logic [NB_W-1:0]     far_next;

	// circular neighbour index
	assign nb_sum = {1'b0, i_q} + (IDX_W + 1)'(j_q);
	assign nb     = (nb_sum >= (IDX_W + 1)'(SAMPLES)) ?
		IDX_W'(nb_sum - (IDX_W + 1)'(SAMPLES)) : IDX_W'(nb_sum);

	assign tt = {{(DATA_W - THR_W){1'b0}}, thr_q};

	always_comb begin
		ax = local_time;
		ay = center_time;
		bx = center_time;
		by = local_time;
		if (state_q == S_CLD) begin
			ax = rd0_q[DATA_W-1:0];
			ay = rd1_q[DATA_W-1:0];
			bx = rd1_q[DATA_W-1:0];
			by = rd0_q[DATA_W-1:0];
		end else if (state_q == S_MLD) begin
			ax = best_q;
			ay = rd0_q[DATA_W-1:0];
		end
	end

	assign load_a = (state_q == S_IDLE && start && crc_ok) || state_q == S_CLD ||
		state_q == S_MLD;
	assign load_b = (state_q == S_IDLE && start && crc_ok) || state_q == S_CLD;
	assign step   = state_q == S_SUB || state_q == S_CRUN || state_q == S_MRUN;

	coe_serial_sub u_sub_a (
		.clk(clk), .arst_n(arst_n), .load(load_a), .step(step),
		.x(ax), .y(ay), .t(tt),
		.diff(a_diff), .borrow(a_bor), .nonzero(a_nz), .t_borrow(a_tb)
	);

	coe_serial_sub u_sub_b (
		.clk(clk), .arst_n(arst_n), .load(load_b), .step(step),
		.x(bx), .y(by), .t(tt),
		.diff(b_diff), .borrow(b_bor), .nonzero(b_nz), .t_borrow(b_tb)
	);

	// local equal to center counts as negative
	assign s_neg    = a_bor | ~a_nz;
	assign wr_en    = state_q == S_WR;
	assign wr_data  = {s_neg, s_neg ? b_diff : a_diff};
	assign rd0_addr = i_q;
	assign rd1_addr = nb;

	assign far_hit  = a_bor ? b_tb : a_tb;
	assign far_next = far_q + NB_W'(far_hit);
	assign sens_req = single_q & ~sens_q & log_q;

	// negatives beat positives; among negatives larger wins, among positives smaller
	assign take = ~have_q | (g_q & ~bn_q) | (~g_q & ~bn_q & ~a_bor & a_nz) |
		(g_q & bn_q & a_bor);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q] <= wr_data;
		end
		rd0_q <= mem[rd0_addr];
		rd1_q <= mem[rd1_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			single_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD:    thr_q    <= cfg_data;
				CFG_SINGLE_TOUCH: single_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			far_q    <= '0;
			listed_q <= '0;
			black_q  <= '0;
			cnt_q    <= '0;
			have_q   <= 1'b0;
			done_q   <= 1'b0;
			resp_q   <= 1'b0;
			oval_q   <= 1'b0;
			oneg_q   <= 1'b0;
			omag_q   <= '0;
			ssens_q  <= 1'b0;
			rdone_q  <= 1'b0;
			log_q    <= 1'b0;
			sens_q   <= 1'b0;
			disc_q   <= 1'b0;
			best_q   <= '0;
			bn_q     <= 1'b0;
			m_q      <= '0;
			g_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						log_q  <= log_flag;
						sens_q <= is_sensing;
						disc_q <= discard_round;
						cnt_q  <= '0;
						if (crc_ok) begin
							state_q <= S_SUB;
						end else begin
							done_q  <= 1'b1;
							resp_q  <= 1'b0;
							oval_q  <= 1'b0;
							oneg_q  <= 1'b0;
							omag_q  <= '0;
							ssens_q <= 1'b0;
							rdone_q <= 1'b0;
						end
					end
				end
				S_SUB: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIGITS - 1)) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					oval_q <= 1'b0;
					oneg_q <= 1'b0;
					omag_q <= '0;
					if (count_q < IDX_W'(SAMPLES - 1)) begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						resp_q  <= 1'b0;
						ssens_q <= 1'b0;
						rdone_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						count_q <= '0;
						if (disc_q) begin
							done_q  <= 1'b1;
							resp_q  <= 1'b1;
							ssens_q <= sens_req;
							rdone_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							black_q  <= '0;
							listed_q <= '0;
							i_q      <= '0;
							j_q      <= NB_W'(1);
							far_q    <= '0;
							state_q  <= S_CRD;
						end
					end
				end
				S_CRD: begin
					state_q <= S_CLD;
				end
				S_CLD: begin
					cnt_q   <= '0;
					state_q <= S_CRUN;
				end
				S_CRUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIGITS - 1)) begin
						state_q <= S_CEV;
					end
				end
				S_CEV: begin
					state_q <= S_CRD;
					if (j_q == NB_W'(NEIGH)) begin
						if (far_next >= NB_W'(FAR_NEED) && listed_q < LIST_W'(MAX_OUT)) begin
							black_q[i_q] <= 1'b1;
							listed_q     <= listed_q + 1'b1;
						end
						far_q <= '0;
						j_q   <= NB_W'(1);
						if (i_q == IDX_W'(SAMPLES - 1)) begin
							i_q     <= '0;
							have_q  <= 1'b0;
							best_q  <= '0;
							bn_q    <= 1'b0;
							state_q <= S_MRD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						far_q <= far_next;
						j_q   <= j_q + 1'b1;
					end
				end
				S_MRD: begin
					if (black_q[i_q]) begin
						if (i_q == IDX_W'(SAMPLES - 1)) begin
							done_q  <= 1'b1;
							resp_q  <= 1'b1;
							oval_q  <= 1'b1;
							oneg_q  <= bn_q;
							omag_q  <= best_q;
							ssens_q <= sens_req;
							rdone_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						state_q <= S_MLD;
					end
				end
				S_MLD: begin
					m_q     <= rd0_q[DATA_W-1:0];
					g_q     <= rd0_q[DATA_W];
					cnt_q   <= '0;
					state_q <= S_MRUN;
				end
				S_MRUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIGITS - 1)) begin
						state_q <= S_MEV;
					end
				end
				S_MEV: begin
					have_q <= 1'b1;
					if (take) begin
						best_q <= m_q;
						bn_q   <= g_q;
					end
					if (i_q == IDX_W'(SAMPLES - 1)) begin
						done_q  <= 1'b1;
						resp_q  <= 1'b1;
						oval_q  <= 1'b1;
						oneg_q  <= take ? g_q : bn_q;
						omag_q  <= take ? m_q : best_q;
						ssens_q <= sens_req;
						rdone_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy             = state_q != S_IDLE;
	assign cfg_ready        = 1'b1;
	assign done             = done_q;
	assign response         = resp_q;
	assign offset_valid     = oval_q;
	assign offset_negative  = oneg_q;
	assign offset_magnitude = omag_q;
	assign start_sensing    = ssens_q;
	assign round_done       = rdone_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < IDX_W'(SAMPLES))
		else $error("sample count out of range");

	a_black_list: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(black_q) == 32'(listed_q))
		else $error("blacklist flags disagree with outlier count");

	a_offset_round: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && oval_q |-> rdone_q && resp_q && !disc_q)
		else $error("offset reported outside a closed round");

endmodule
